// ===== rtl/rhht_pkg.sv =====
// Shared types and constants for the Robin Hood hash table.
// Holds the request and response beats and the controller/datapath interface.
// Depends on nothing.
package rhht_pkg;

  localparam int unsigned DefaultDepth   = 1024;
  localparam int unsigned DefaultKeyBits = 64;
  localparam int unsigned KeyW           = 64;
  localparam int unsigned HashW          = 48;
  localparam int unsigned ValueW         = 64;
  localparam int unsigned LimitW         = 11;
  localparam int unsigned CountW         = 11;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(768);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [KeyW-1:0]   key;
    logic [HashW-1:0]  key_hash;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ValueW-1:0] found_value;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    home_step;
    logic    rd_first;
    logic    advance;
    logic    swap;
    logic    place;
    logic    del_start;
    logic    shift_move;
    logic    shift_end;
    logic    dec_count;
    logic    respond;
    logic    take_value;
    status_e code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  clear_last;
    logic  home_done;
    logic  full;
    logic  empty;
    logic  match;
    logic  less;
    logic  le1;
    logic  probe_last;
    mode_e mode;
  } stat_t;

endpackage

// ===== rtl/rhht_ctrl.sv =====
// Controller state machine of the Robin Hood hash table.
// Sequences clearing, home bucket reduction, probing and backward shift.
// Depends on rhht_pkg.
module rhht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rhht_pkg::stat_t stat_i,
  output rhht_pkg::cmd_t  cmd_o
);
  import rhht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HOME  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_SHIFT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_NOT_FOUND;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_HOME;
        end
      end
      S_HOME: begin
        if (!stat_i.home_done) begin
          cmd_o.home_step = 1'b1;
        end else if (stat_i.mode == MODE_INSERT && stat_i.full) begin
          cmd_o.respond = 1'b1;
          cmd_o.code    = ST_FULL;
          state_d       = S_IDLE;
        end else if (stat_i.mode == MODE_UNUSED) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (stat_i.mode == MODE_INSERT) begin
          if (stat_i.empty) begin
            cmd_o.place   = 1'b1;
            cmd_o.respond = 1'b1;
            cmd_o.code    = ST_INSERTED;
            state_d       = S_IDLE;
          end else if (stat_i.match) begin
            cmd_o.respond = 1'b1;
            cmd_o.code    = ST_DUPLICATE;
            state_d       = S_IDLE;
          end else begin
            cmd_o.swap    = stat_i.less;
            cmd_o.advance = 1'b1;
          end
        end else if (stat_i.empty) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else if (stat_i.match) begin
          if (stat_i.mode == MODE_LOOKUP) begin
            cmd_o.respond    = 1'b1;
            cmd_o.take_value = 1'b1;
            cmd_o.code       = ST_FOUND;
            state_d          = S_IDLE;
          end else begin
            cmd_o.del_start = 1'b1;
            state_d         = S_SHIFT;
          end
        end else if (stat_i.probe_last) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.le1) begin
          cmd_o.shift_end = 1'b1;
          cmd_o.dec_count = 1'b1;
          cmd_o.respond   = 1'b1;
          cmd_o.code      = ST_DELETED;
          state_d         = S_IDLE;
        end else if (stat_i.probe_last) begin
          // The shift wrapped the whole table: the last move stands, no bucket empties.
          cmd_o.shift_move = 1'b1;
          cmd_o.dec_count  = 1'b1;
          cmd_o.respond    = 1'b1;
          cmd_o.code       = ST_DELETED;
          state_d          = S_IDLE;
        end else begin
          cmd_o.shift_move = 1'b1;
          cmd_o.advance    = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rhht_dp.sv =====
// Datapath of the Robin Hood hash table: bucket memory, carried entry,
// probe index, home reduction, entry count, load limit and response register.
// Depends on rhht_pkg.
module rhht_dp #(
  parameter int unsigned DEPTH    = rhht_pkg::DefaultDepth,
  parameter int unsigned KEY_BITS = rhht_pkg::DefaultKeyBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rhht_pkg::req_t               req_i,
  input  logic                         cfg_we_i,
  input  logic [rhht_pkg::LimitW-1:0]  cfg_wdata_i,
  input  rhht_pkg::cmd_t               cmd_i,
  output rhht_pkg::stat_t              stat_o,
  output logic                         done_o,
  output rhht_pkg::rsp_t               rsp_o
);
  import rhht_pkg::*;

  localparam int unsigned IdxW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned DistW  = CntW;
  localparam int unsigned CmpW   = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned HcntW  = $clog2(HashW + 1);
  localparam bit          Pow2   = ((DEPTH & (DEPTH - 1)) == 0);

  typedef struct packed {
    logic [DistW-1:0]    pdist;
    logic [HashW-1:0]    hash;
    logic [KEY_BITS-1:0] key;
    logic [ValueW-1:0]   value;
  } slot_t;

  slot_t mem [DEPTH];
  slot_t rd_q;
  slot_t carry_q, carry_d;
  slot_t wr_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;

  logic [IdxW-1:0]   idx_q, idx_d, idx_nxt, prev_q, prev_d, probe_q, probe_d, clr_q;
  logic [IdxW:0]     rem_q, rem_d, rem_sh, rem_red;
  logic [HcntW-1:0]  hcnt_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [LimitW-1:0] limit_q;
  mode_e             mode_q;
  logic              done_q;
  rsp_t              rsp_q;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] a);
    if (a == IdxW'(DEPTH - 1)) begin
      return '0;
    end
    return a + 1'b1;
  endfunction

  assign idx_nxt = nxt(idx_q);

  // Home bucket for a table size that is not a power of two: one hash bit a cycle.
  assign rem_sh  = {rem_q[IdxW-1:0], carry_q.hash[HcntW'(hcnt_q - 1'b1)]};
  assign rem_red = (rem_sh >= (IdxW + 1)'(DEPTH)) ? rem_sh - (IdxW + 1)'(DEPTH) : rem_sh;

  always_comb begin
    stat_o.clear_last = (clr_q == IdxW'(DEPTH - 1));
    stat_o.home_done  = (hcnt_q == '0);
    stat_o.full       = (CmpW'(count_q) >= CmpW'(limit_q)) || (count_q >= CntW'(DEPTH));
    stat_o.empty      = (rd_q.pdist == '0);
    stat_o.match      = (rd_q.hash == carry_q.hash) && (rd_q.key == carry_q.key);
    stat_o.less       = (rd_q.pdist < carry_q.pdist);
    stat_o.le1        = (rd_q.pdist <= DistW'(1));
    stat_o.probe_last = (probe_q == IdxW'(DEPTH - 1));
    stat_o.mode       = mode_q;
  end

  // Memory port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = carry_q;
    rd_addr = cmd_i.rd_first ? idx_q : idx_nxt;
    if (cmd_i.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (cmd_i.place || cmd_i.swap) begin
      wr_en   = 1'b1;
    end else if (cmd_i.shift_move) begin
      wr_en         = 1'b1;
      wr_addr       = prev_q;
      wr_data       = rd_q;
      wr_data.pdist = rd_q.pdist - 1'b1;
    end else if (cmd_i.shift_end) begin
      wr_en         = 1'b1;
      wr_addr       = prev_q;
      wr_data       = rd_q;
      wr_data.pdist = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Next values of the walk.
  always_comb begin
    carry_d = carry_q;
    idx_d   = idx_q;
    prev_d  = prev_q;
    probe_d = probe_q;
    rem_d   = rem_q;
    if (cmd_i.load) begin
      carry_d.pdist = DistW'(1);
      carry_d.hash  = req_i.key_hash;
      carry_d.key   = req_i.key[KEY_BITS-1:0];
      carry_d.value = req_i.value;
      idx_d         = Pow2 ? req_i.key_hash[IdxW-1:0] : '0;
      rem_d         = '0;
    end
    if (cmd_i.home_step) begin
      rem_d = rem_red;
      idx_d = rem_red[IdxW-1:0];
    end
    if (cmd_i.rd_first) begin
      probe_d = '0;
    end
    if (cmd_i.swap) begin
      carry_d = rd_q;
    end
    if (cmd_i.shift_move) begin
      prev_d = idx_q;
    end
    if (cmd_i.advance) begin
      idx_d         = idx_nxt;
      probe_d       = probe_q + 1'b1;
      carry_d.pdist = (cmd_i.swap ? rd_q.pdist : carry_q.pdist) + 1'b1;
    end
    if (cmd_i.del_start) begin
      prev_d  = idx_q;
      idx_d   = idx_nxt;
      probe_d = '0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.place) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.dec_count && count_q != '0) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    idx_q   <= idx_d;
    prev_q  <= prev_d;
    probe_q <= probe_d;
    rem_q   <= rem_d;
    if (cmd_i.load) begin
      mode_q <= mode_e'(req_i.mode);
    end
    if (cmd_i.respond) begin
      rsp_q.status      <= cmd_i.code;
      rsp_q.found_value <= cmd_i.take_value ? rd_q.value : '0;
      rsp_q.entry_count <= CountW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      hcnt_q  <= '0;
      count_q <= '0;
      limit_q <= LimitReset;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        hcnt_q <= Pow2 ? '0 : HcntW'(HashW);
      end else if (cmd_i.home_step) begin
        hcnt_q <= hcnt_q - 1'b1;
      end
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      done_q <= cmd_i.respond;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/robin_hood_hash_table.sv =====
// Top level of the Robin Hood hash table with backward-shift delete.
// Joins rhht_ctrl and rhht_dp; depends on rhht_pkg.
//
//   Channel   Ports                     Handshake
//   request   start, busy, req_i        beat taken when start && !busy
//   response  done_o, rsp_o             one-cycle strobe, cannot be held off
//   config    cfg_we_i, cfg_wdata_i     written on any edge with cfg_we_i
//
// The response strobe follows the probe of each bucket (plus the shift, for a
// delete), one bucket a cycle through the bucket memory with one read and one
// write port; a refused insert or an unused mode responds once the home bucket is
// known. When DEPTH is not a power of two the home bucket is reduced one hash bit
// a cycle.
// After reset a clearing pass over all DEPTH buckets empties the memory, busy high.
// The response is registered; busy falls in the cycle the strobe shows.
module robin_hood_hash_table #(
  parameter int unsigned DEPTH    = rhht_pkg::DefaultDepth,
  parameter int unsigned KEY_BITS = rhht_pkg::DefaultKeyBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  rhht_pkg::req_t              req_i,
  output logic                        done_o,
  output rhht_pkg::rsp_t              rsp_o,
  input  logic                        cfg_we_i,
  input  logic [rhht_pkg::LimitW-1:0] cfg_wdata_i
);
  import rhht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rhht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rhht_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/rhht_checker.sv =====
// Port-level checks for the Robin Hood hash table, bound to the top level.
// Depends on rhht_pkg and robin_hood_hash_table.
module rhht_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input rhht_pkg::rsp_t rsp_o
);
  import rhht_pkg::*;

  // A response beat comes only once the operation has released the block.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("response while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two response beats in a row");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status <= 3'(ST_FULL))) else $error("undefined status code");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != 3'(ST_FOUND)) |-> (rsp_o.found_value == '0))
    else $error("found_value nonzero without a hit");

endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
